>>> rtl/core/ftcs_pkg.sv
// ----------------------------------------------------------------------------
// ftcs_pkg: shared types and constants of the floor texture coordinate stepper
// Word formats, camera register set, queue entry and row setup result.
// ----------------------------------------------------------------------------
package ftcs_pkg;

	// fixed point
	localparam int ONE_Q16   = 65536;
	localparam int FRAC_W    = 16;
	localparam int ACC_W     = 40;
	localparam int WIDE_W    = 48;
	localparam int MUL_B_W   = 19;
	localparam int TEX_BITS  = 11;
	localparam int TEX_OUT_W = 6;
	localparam int CELL_W    = 24;
	localparam int ROW_W     = 10;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;

	// register reset values
	localparam logic [23:0]        POS_RST     = 24'd0;
	localparam logic signed [17:0] DIR_X_RST   = 18'sd65536;
	localparam logic signed [17:0] DIR_Y_RST   = 18'sd0;
	localparam logic signed [17:0] PLANE_X_RST = 18'sd0;
	localparam logic signed [17:0] PLANE_Y_RST = 18'sd43253;

	// input word kinds
	localparam logic KIND_ROW   = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// item queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// saturation limits of the 40-bit accumulators
	localparam logic signed [WIDE_W-1:0] ACC_MAX = 48'sh007F_FFFF_FFFF;
	localparam logic signed [WIDE_W-1:0] ACC_MIN = 48'shFF80_0000_0000;

	typedef struct packed {
		logic       kind;
		logic [9:0] screen_row;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] cell_x;
		logic signed [23:0] cell_y;
		logic [5:0]         tex_x;
		logic [5:0]         tex_y;
		logic               result_valid;
	} out_item_t;

	typedef struct packed {
		logic [23:0]        pos_x;
		logic [23:0]        pos_y;
		logic signed [17:0] dir_x;
		logic signed [17:0] dir_y;
		logic signed [17:0] plane_x;
		logic signed [17:0] plane_y;
	} cam_cfg_t;

	typedef enum logic [1:0] {
		CLS_PIXEL,
		CLS_ROW,
		CLS_HORIZON
	} cls_t;

	typedef struct packed {
		cls_t             cls;
		logic             neg;
		logic [ROW_W-1:0] mag;
	} q_entry_t;

	typedef struct packed {
		logic                    valid;
		logic signed [ACC_W-1:0] step_x;
		logic signed [ACC_W-1:0] step_y;
		logic signed [ACC_W-1:0] point_x;
		logic signed [ACC_W-1:0] point_y;
	} row_setup_t;

	// clamp a wide signed value to the 40-bit accumulator range
	function automatic logic signed [ACC_W-1:0] sat40(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] c;
		c = v;
		if (v > ACC_MAX) c = ACC_MAX;
		if (v < ACC_MIN) c = ACC_MIN;
		return c[ACC_W-1:0];
	endfunction

endpackage

>>> rtl/core/ftcs_front.sv
// ----------------------------------------------------------------------------
// ftcs_front: input classification and item queue
// Sorts each input word into pixel, row start or horizon row, takes the row
// offset apart into sign and magnitude, and queues it for the back end.
// ----------------------------------------------------------------------------
module ftcs_front import ftcs_pkg::*; #(
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     head_valid,
	output q_entry_t head,
	input  logic     pop
);

	localparam logic signed [ROW_W:0] HALF_H = (ROW_W + 1)'(SCREEN_HEIGHT / 2);

	q_entry_t          queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic signed [ROW_W:0] offset;
	logic [ROW_W:0]        offset_mag;
	q_entry_t              entry;
	logic                  push;

	// row offset from the horizon and word class
	always_comb begin
		offset     = $signed({1'b0, in_data.screen_row}) - HALF_H;
		offset_mag = offset[ROW_W] ? (ROW_W + 1)'(-offset) : offset;
		entry.neg  = offset[ROW_W];
		entry.mag  = offset_mag[ROW_W-1:0];
		if (in_data.kind == KIND_PIXEL) begin
			entry.cls = CLS_PIXEL;
		end else if (offset == '0) begin
			entry.cls = CLS_HORIZON;
		end else begin
			entry.cls = CLS_ROW;
		end
	end

	assign in_ready   = (cnt_q != QCNT_W'(QDEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (cnt_q != '0);
	assign head       = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/ftcs_row_setup.sv
// ----------------------------------------------------------------------------
// ftcs_row_setup: row start sequencer
// Works out row distance, per-pixel step and start point of a floor row with
// a restoring divider for the row distance that yields a bit a cycle, one
// shared multiplier, and a reciprocal multiplier for the screen width divide.
// ----------------------------------------------------------------------------
module ftcs_row_setup import ftcs_pkg::*; #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             neg,
	input  logic [ROW_W-1:0] mag,
	input  cam_cfg_t         cam,
	output logic             busy,
	output row_setup_t       res
);

	localparam int ROW_NUM = SCREEN_HEIGHT * (ONE_Q16 / 2);
	localparam int RD_W    = $clog2(ROW_NUM + 1);
	localparam int PW      = RD_W + MUL_B_W;
	localparam int CNT_W   = $clog2(RD_W + 1);

	// step divide by SCREEN_WIDTH*2^16: drop the 16 fraction bits, then
	// multiply by the rounded-up reciprocal of the width, exact over QN_W bits
	localparam int     QN_W    = PW - FRAC_W;
	localparam int     W_LOG   = $clog2(SCREEN_WIDTH);
	localparam int     REC_S   = QN_W + W_LOG;
	localparam int     REC_M_W = QN_W + 1;
	localparam int     REC_P_W = QN_W + REC_M_W;
	localparam longint REC_M   = ((longint'(1) <<< REC_S) + longint'(SCREEN_WIDTH) - 1)
		/ longint'(SCREEN_WIDTH);
	localparam logic [REC_M_W-1:0] REC_M_V = REC_M_W'(REC_M);

	typedef enum logic [3:0] {
		IDLE,
		DIV_ROW,
		MUL_SX,
		REC_SX,
		STO_SX,
		MUL_SY,
		REC_SY,
		STO_SY,
		MUL_PX,
		ADD_PX,
		MUL_PY,
		ADD_PY,
		FIN
	} state_t;

	state_t                  state_q;
	logic [RD_W-1:0]         dvd_q;
	logic [ROW_W-1:0]        rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [RD_W-1:0]         rd_q;
	logic                    neg_q;
	logic [ROW_W-1:0]        mag_q;
	logic [PW-1:0]           prod_q;
	logic [REC_P_W-1:0]      rec_q;
	logic signed [ACC_W-1:0] step_x_q;
	logic signed [ACC_W-1:0] step_y_q;
	logic signed [ACC_W-1:0] point_x_q;
	logic signed [ACC_W-1:0] point_y_q;

	logic [ROW_W:0]             trial;
	logic                       ge;
	logic [ROW_W-1:0]           rem_nx;
	logic [RD_W-1:0]            dvd_nx;
	logic signed [MUL_B_W-1:0]  two_px;
	logic signed [MUL_B_W-1:0]  two_py;
	logic signed [MUL_B_W-1:0]  diff_x;
	logic signed [MUL_B_W-1:0]  diff_y;
	logic [MUL_B_W-1:0]         mul_b;
	logic                       step_neg;
	logic [WIDE_W-1:0]          step_mag;
	logic signed [WIDE_W-1:0]   step_val;
	logic                       pt_neg;
	logic [23:0]                pt_pos;
	logic [WIDE_W-1:0]          pt_mag;
	logic signed [WIDE_W-1:0]   pt_sum;

	// restoring divider step for the row distance
	always_comb begin
		trial  = {rem_q, dvd_q[RD_W-1]};
		ge     = (trial >= {1'b0, mag_q});
		rem_nx = ge ? ROW_W'(trial - {1'b0, mag_q}) : trial[ROW_W-1:0];
		dvd_nx = {dvd_q[RD_W-2:0], ge};
	end

	// multiplier operand: magnitude of twice the plane or of direction minus plane
	always_comb begin
		two_px = {cam.plane_x, 1'b0};
		two_py = {cam.plane_y, 1'b0};
		diff_x = $signed({cam.dir_x[17], cam.dir_x}) - $signed({cam.plane_x[17], cam.plane_x});
		diff_y = $signed({cam.dir_y[17], cam.dir_y}) - $signed({cam.plane_y[17], cam.plane_y});
		unique case (state_q)
			MUL_SX:  mul_b = two_px[MUL_B_W-1] ? MUL_B_W'(-two_px) : two_px;
			MUL_SY:  mul_b = two_py[MUL_B_W-1] ? MUL_B_W'(-two_py) : two_py;
			MUL_PX:  mul_b = diff_x[MUL_B_W-1] ? MUL_B_W'(-diff_x) : diff_x;
			MUL_PY:  mul_b = diff_y[MUL_B_W-1] ? MUL_B_W'(-diff_y) : diff_y;
			default: mul_b = '0;
		endcase
	end

	// signed step from the reciprocal product
	always_comb begin
		step_neg = neg_q ^ ((state_q == STO_SY) ? cam.plane_y[17] : cam.plane_x[17]);
		step_mag = WIDE_W'(rec_q[REC_P_W-1:REC_S]);
		step_val = step_neg ? -$signed(step_mag) : $signed(step_mag);
	end

	// start point: camera position plus scaled direction minus plane
	always_comb begin
		pt_neg = neg_q ^ ((state_q == ADD_PY) ? diff_y[MUL_B_W-1] : diff_x[MUL_B_W-1]);
		pt_pos = (state_q == ADD_PY) ? cam.pos_y : cam.pos_x;
		pt_mag = WIDE_W'(prod_q[PW-1:FRAC_W]);
		pt_sum = $signed(WIDE_W'(pt_pos)) + (pt_neg ? -$signed(pt_mag) : $signed(pt_mag));
	end

	// shared multiplier and reciprocal multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= PW'(rd_q) * PW'(mul_b);
		rec_q  <= REC_P_W'(prod_q[PW-1:FRAC_W]) * REC_P_W'(REC_M_V);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			dvd_q     <= '0;
			rem_q     <= '0;
			cnt_q     <= '0;
			rd_q      <= '0;
			neg_q     <= 1'b0;
			mag_q     <= '0;
			step_x_q  <= '0;
			step_y_q  <= '0;
			point_x_q <= '0;
			point_y_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (start) begin
						neg_q   <= neg;
						mag_q   <= mag;
						dvd_q   <= RD_W'(ROW_NUM);
						rem_q   <= '0;
						cnt_q   <= CNT_W'(RD_W);
						state_q <= DIV_ROW;
					end
				end
				DIV_ROW: begin
					dvd_q <= dvd_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						rd_q    <= dvd_nx;
						state_q <= MUL_SX;
					end
				end
				MUL_SX: state_q <= REC_SX;
				REC_SX: state_q <= STO_SX;
				STO_SX: begin
					step_x_q <= sat40(step_val);
					state_q  <= MUL_SY;
				end
				MUL_SY: state_q <= REC_SY;
				REC_SY: state_q <= STO_SY;
				STO_SY: begin
					step_y_q <= sat40(step_val);
					state_q  <= MUL_PX;
				end
				MUL_PX: state_q <= ADD_PX;
				ADD_PX: begin
					point_x_q <= sat40(pt_sum);
					state_q   <= MUL_PY;
				end
				MUL_PY: state_q <= ADD_PY;
				ADD_PY: begin
					point_y_q <= sat40(pt_sum);
					state_q   <= FIN;
				end
				FIN:     state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assign busy        = (state_q != IDLE);
	assign res.valid   = (state_q == FIN);
	assign res.step_x  = step_x_q;
	assign res.step_y  = step_y_q;
	assign res.point_x = point_x_q;
	assign res.point_y = point_y_q;

endmodule

>>> rtl/core/ftcs_back.sv
// ----------------------------------------------------------------------------
// ftcs_back: item execution and floor point stepper
// Takes queued words, runs row starts through the setup sequencer, and for
// each pixel emits cell and texture coordinates and advances the point.
// ----------------------------------------------------------------------------
module ftcs_back import ftcs_pkg::*; #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480,
	parameter int TEX_WIDTH     = 64,
	parameter int TEX_HEIGHT    = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  q_entry_t  head,
	output logic      pop,
	input  cam_cfg_t  cam,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int TP_W = FRAC_W + TEX_BITS;

	logic                    horizon_q;
	logic signed [ACC_W-1:0] point_x_q;
	logic signed [ACC_W-1:0] point_y_q;
	logic signed [ACC_W-1:0] step_x_q;
	logic signed [ACC_W-1:0] step_y_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic          busy;
	row_setup_t    setup;
	logic          start;
	logic          out_free;
	logic          load_out;
	logic          advance;
	logic          set_horizon;
	logic [TP_W-1:0]     tx_prod;
	logic [TP_W-1:0]     ty_prod;
	logic [TEX_BITS-1:0] tx_sel;
	logic [TEX_BITS-1:0] ty_sel;
	out_item_t     pix;

	ftcs_row_setup #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_row_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.neg    (head.neg),
		.mag    (head.mag),
		.cam    (cam),
		.busy   (busy),
		.res    (setup)
	);

	assign out_free = !out_valid_q || out_ready;

	// dispatch of the word at the queue head
	always_comb begin
		pop         = 1'b0;
		start       = 1'b0;
		load_out    = 1'b0;
		advance     = 1'b0;
		set_horizon = 1'b0;
		if (head_valid && !busy) begin
			unique case (head.cls)
				CLS_PIXEL: begin
					if (out_free) begin
						pop      = 1'b1;
						load_out = 1'b1;
						advance  = !horizon_q;
					end
				end
				CLS_ROW: begin
					pop   = 1'b1;
					start = 1'b1;
				end
				CLS_HORIZON: begin
					pop         = 1'b1;
					set_horizon = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// pixel result: cell is the floor, texture from the fraction; all zero on a horizon row
	always_comb begin
		tx_prod = TP_W'(point_x_q[FRAC_W-1:0]) * TP_W'(TEX_WIDTH);
		ty_prod = TP_W'(point_y_q[FRAC_W-1:0]) * TP_W'(TEX_HEIGHT);
		tx_sel  = tx_prod[TP_W-1:FRAC_W] & TEX_BITS'(TEX_WIDTH - 1);
		ty_sel  = ty_prod[TP_W-1:FRAC_W] & TEX_BITS'(TEX_HEIGHT - 1);
		if (horizon_q) begin
			pix = '0;
		end else begin
			pix.cell_x       = point_x_q[ACC_W-1:FRAC_W];
			pix.cell_y       = point_y_q[ACC_W-1:FRAC_W];
			pix.tex_x        = tx_sel[TEX_OUT_W-1:0];
			pix.tex_y        = ty_sel[TEX_OUT_W-1:0];
			pix.result_valid = 1'b1;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= pix;
		end
	end

	// row state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizon_q   <= 1'b1;
			point_x_q   <= '0;
			point_y_q   <= '0;
			step_x_q    <= '0;
			step_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (setup.valid) begin
				horizon_q <= 1'b0;
				point_x_q <= setup.point_x;
				point_y_q <= setup.point_y;
				step_x_q  <= setup.step_x;
				step_y_q  <= setup.step_y;
			end else if (set_horizon) begin
				horizon_q <= 1'b1;
				point_x_q <= '0;
				point_y_q <= '0;
				step_x_q  <= '0;
				step_y_q  <= '0;
			end else if (advance) begin
				point_x_q <= sat40(WIDE_W'(point_x_q) + WIDE_W'(step_x_q));
				point_y_q <= sat40(WIDE_W'(point_y_q) + WIDE_W'(step_y_q));
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/core/floor_texture_coordinate_stepper.sv
// ----------------------------------------------------------------------------
// floor_texture_coordinate_stepper: raycaster floor casting address generator
// Pixel word: via queue and output word register, one pixel word per cycle
// sustained unless output stalls or row setup runs. Row start word: holds the
// back end in row setup (RD_W = bits of SCREEN_HEIGHT*32768; 24 at defaults).
// Reset: async, clears queue and sequencer, registers to defaults, no sweep.
// ----------------------------------------------------------------------------
module floor_texture_coordinate_stepper import ftcs_pkg::*; #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480,
	parameter int TEX_WIDTH     = 64,
	parameter int TEX_HEIGHT    = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cam_cfg_t cam_q;
	logic     head_valid;
	q_entry_t head;
	logic     pop;

	// camera register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q.pos_x   <= POS_RST;
			cam_q.pos_y   <= POS_RST;
			cam_q.dir_x   <= DIR_X_RST;
			cam_q.dir_y   <= DIR_Y_RST;
			cam_q.plane_x <= PLANE_X_RST;
			cam_q.plane_y <= PLANE_Y_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POS_X:   cam_q.pos_x   <= cfg_data;
				CFG_POS_Y:   cam_q.pos_y   <= cfg_data;
				CFG_DIR_X:   cam_q.dir_x   <= cfg_data[17:0];
				CFG_DIR_Y:   cam_q.dir_y   <= cfg_data[17:0];
				CFG_PLANE_X: cam_q.plane_x <= cfg_data[17:0];
				CFG_PLANE_Y: cam_q.plane_y <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	ftcs_front #(
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	ftcs_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TEX_WIDTH     (TEX_WIDTH),
		.TEX_HEIGHT    (TEX_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.cam        (cam_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
